>>> sv/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types, sizes and codes of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int ADDR_BITS   = 16;
    localparam int TAG_BITS    = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int OFF_W       = ADDR_BITS + IDX_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int POL_W       = 2;

    localparam logic [ADDR_BITS-1:0] RESET_UNITS = ADDR_BITS'(1024);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_UNITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 1'b1;

    // fit policy codes, anything else is first fit
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_COMPACT = 2'd2,
        OP_REINIT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_HOLE = 2'd1,
        ST_NO_TAG  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic                 used;
        logic [TAG_BITS-1:0]  tag;
        logic [ADDR_BITS-1:0] size;
        logic [ADDR_BITS-1:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_REINIT,
        CMD_FAIL_HOLE,
        CMD_FAIL_TAG,
        CMD_FAIL_FULL,
        CMD_SCAN_RD,
        CMD_ALLOC_EVAL,
        CMD_ALLOC_EXACT,
        CMD_SPLIT_INIT,
        CMD_MOVE_RD,
        CMD_MOVE_WR,
        CMD_SPLIT_HOLE,
        CMD_SPLIT_BLOCK,
        CMD_FREE_HIT,
        CMD_FREE_MISS,
        CMD_NEXT_RD,
        CMD_NEXT_EVAL,
        CMD_MERGE,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_FREE_END,
        CMD_COMPACT_EVAL,
        CMD_COMPACT_TAIL
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic req_zero;
        logic at_end;
        logic have;
        logic exact;
        logic full;
        logic hit;
        logic move_done;
        logic shift_done;
    } t_dp_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_A_RD,
        S_A_EV,
        S_A_DEC,
        S_A_MV_RD,
        S_A_MV_WR,
        S_A_HOLE,
        S_A_BLK,
        S_F_RD,
        S_F_EV,
        S_F_NRD,
        S_F_NEV,
        S_F_MRG,
        S_F_SH_RD,
        S_F_SH_WR,
        S_C_RD,
        S_C_EV,
        S_OUT
    } t_state;

endpackage

>>> sv/variable_partition_allocator_unit.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// Address-ordered block table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered by one result word. The
// table lives in a 128-word RAM with one read and one write port, so every
// table word is first read and then used or rewritten. Allocate scans the
// table and, for a split, moves the entries above the picked hole up; free
// scans up to the match, reads the next entry, writes the merged block and
// moves the later entries down; compact scans every entry and then writes
// the tail; reinitialize resets the table. After reset the init state writes
// the initial hole before the first word is taken. Registers are to be
// written only while the block is idle; the block does not enforce this.
module variable_partition_allocator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // op, owner_tag, request_size
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // status, block_start, block_size
    input  logic                           i_cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    vpa_pkg::t_cmd       cmd;
    vpa_pkg::t_dp_status dp_status;
    logic [1:0]          res_status;
    logic [15:0]         res_start;
    logic [15:0]         res_size;

    vpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    vpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (s_axis_tdata[1:0]),
        .i_tag        (s_axis_tdata[9:2]),
        .i_req        (s_axis_tdata[25:10]),
        .o_status     (dp_status),
        .o_res_status (res_status),
        .o_res_start  (res_start),
        .o_res_size   (res_size)
    );

    assign m_axis_tdata = {6'd0, res_size, res_start, res_status};

endmodule

>>> sv/vpa_ram.sv
// ----------------------------------------------------------------------------
// vpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer of the allocator: steps scans, moves and merges one table word
// at a time and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module vpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  vpa_pkg::t_dp_status i_status,
    output vpa_pkg::t_cmd       o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);

    vpa_pkg::t_state r_state;
    vpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vpa_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vpa_pkg::S_INIT:     n_state = vpa_pkg::S_IDLE;
            vpa_pkg::S_IDLE:     if (i_in_valid) n_state = vpa_pkg::S_DISPATCH;
            vpa_pkg::S_DISPATCH: begin
                unique case (i_status.op)
                    vpa_pkg::OP_ALLOC:
                        n_state = i_status.req_zero ? vpa_pkg::S_OUT : vpa_pkg::S_A_RD;
                    vpa_pkg::OP_FREE:    n_state = vpa_pkg::S_F_RD;
                    vpa_pkg::OP_COMPACT: n_state = vpa_pkg::S_C_RD;
                    default:             n_state = vpa_pkg::S_OUT;
                endcase
            end
            vpa_pkg::S_A_RD: begin
                if (!i_status.at_end)     n_state = vpa_pkg::S_A_EV;
                else if (i_status.have)   n_state = vpa_pkg::S_A_DEC;
                else                      n_state = vpa_pkg::S_OUT;
            end
            vpa_pkg::S_A_EV:     n_state = vpa_pkg::S_A_RD;
            vpa_pkg::S_A_DEC: begin
                if (i_status.exact || i_status.full) n_state = vpa_pkg::S_OUT;
                else                                 n_state = vpa_pkg::S_A_MV_RD;
            end
            vpa_pkg::S_A_MV_RD:
                n_state = i_status.move_done ? vpa_pkg::S_A_HOLE : vpa_pkg::S_A_MV_WR;
            vpa_pkg::S_A_MV_WR:  n_state = vpa_pkg::S_A_MV_RD;
            vpa_pkg::S_A_HOLE:   n_state = vpa_pkg::S_A_BLK;
            vpa_pkg::S_A_BLK:    n_state = vpa_pkg::S_OUT;
            vpa_pkg::S_F_RD:
                n_state = i_status.at_end ? vpa_pkg::S_OUT : vpa_pkg::S_F_EV;
            vpa_pkg::S_F_EV:
                n_state = i_status.hit ? vpa_pkg::S_F_NRD : vpa_pkg::S_F_RD;
            vpa_pkg::S_F_NRD:    n_state = vpa_pkg::S_F_NEV;
            vpa_pkg::S_F_NEV:    n_state = vpa_pkg::S_F_MRG;
            vpa_pkg::S_F_MRG:    n_state = vpa_pkg::S_F_SH_RD;
            vpa_pkg::S_F_SH_RD:
                n_state = i_status.shift_done ? vpa_pkg::S_OUT : vpa_pkg::S_F_SH_WR;
            vpa_pkg::S_F_SH_WR:  n_state = vpa_pkg::S_F_SH_RD;
            vpa_pkg::S_C_RD:
                n_state = i_status.at_end ? vpa_pkg::S_OUT : vpa_pkg::S_C_EV;
            vpa_pkg::S_C_EV:     n_state = vpa_pkg::S_C_RD;
            vpa_pkg::S_OUT:      if (i_out_ready) n_state = vpa_pkg::S_IDLE;
            default:             n_state = vpa_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = vpa_pkg::CMD_NONE;
        unique case (r_state)
            vpa_pkg::S_INIT:     o_cmd = vpa_pkg::CMD_INIT;
            vpa_pkg::S_IDLE:     if (i_in_valid) o_cmd = vpa_pkg::CMD_LOAD;
            vpa_pkg::S_DISPATCH: begin
                if (i_status.op == vpa_pkg::OP_ALLOC && i_status.req_zero) begin
                    o_cmd = vpa_pkg::CMD_FAIL_HOLE;
                end else if (i_status.op == vpa_pkg::OP_REINIT) begin
                    o_cmd = vpa_pkg::CMD_REINIT;
                end
            end
            vpa_pkg::S_A_RD: begin
                if (!i_status.at_end)   o_cmd = vpa_pkg::CMD_SCAN_RD;
                else if (!i_status.have) o_cmd = vpa_pkg::CMD_FAIL_HOLE;
            end
            vpa_pkg::S_A_EV:     o_cmd = vpa_pkg::CMD_ALLOC_EVAL;
            vpa_pkg::S_A_DEC: begin
                if (i_status.exact)     o_cmd = vpa_pkg::CMD_ALLOC_EXACT;
                else if (i_status.full) o_cmd = vpa_pkg::CMD_FAIL_FULL;
                else                    o_cmd = vpa_pkg::CMD_SPLIT_INIT;
            end
            vpa_pkg::S_A_MV_RD:  if (!i_status.move_done) o_cmd = vpa_pkg::CMD_MOVE_RD;
            vpa_pkg::S_A_MV_WR:  o_cmd = vpa_pkg::CMD_MOVE_WR;
            vpa_pkg::S_A_HOLE:   o_cmd = vpa_pkg::CMD_SPLIT_HOLE;
            vpa_pkg::S_A_BLK:    o_cmd = vpa_pkg::CMD_SPLIT_BLOCK;
            vpa_pkg::S_F_RD:
                o_cmd = i_status.at_end ? vpa_pkg::CMD_FAIL_TAG : vpa_pkg::CMD_SCAN_RD;
            vpa_pkg::S_F_EV:
                o_cmd = i_status.hit ? vpa_pkg::CMD_FREE_HIT : vpa_pkg::CMD_FREE_MISS;
            vpa_pkg::S_F_NRD:    o_cmd = vpa_pkg::CMD_NEXT_RD;
            vpa_pkg::S_F_NEV:    o_cmd = vpa_pkg::CMD_NEXT_EVAL;
            vpa_pkg::S_F_MRG:    o_cmd = vpa_pkg::CMD_MERGE;
            vpa_pkg::S_F_SH_RD:
                o_cmd = i_status.shift_done ? vpa_pkg::CMD_FREE_END : vpa_pkg::CMD_SHIFT_RD;
            vpa_pkg::S_F_SH_WR:  o_cmd = vpa_pkg::CMD_SHIFT_WR;
            vpa_pkg::S_C_RD:
                o_cmd = i_status.at_end ? vpa_pkg::CMD_COMPACT_TAIL : vpa_pkg::CMD_SCAN_RD;
            vpa_pkg::S_C_EV:     o_cmd = vpa_pkg::CMD_COMPACT_EVAL;
            vpa_pkg::S_OUT:      o_cmd = vpa_pkg::CMD_NONE;
            default:             o_cmd = vpa_pkg::CMD_NONE;
        endcase
    end

    assign o_in_ready  = (r_state == vpa_pkg::S_IDLE);
    assign o_out_valid = (r_state == vpa_pkg::S_OUT);

endmodule

>>> sv/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp
// Datapath of the allocator: block table RAM, scan and move pointers,
// hole selection, merge arithmetic and the result register.
// ----------------------------------------------------------------------------
module vpa_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vpa_pkg::t_cmd                    i_cmd,
    input  logic                             i_cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                       i_op,
    input  logic [vpa_pkg::TAG_BITS-1:0]     i_tag,
    input  logic [vpa_pkg::ADDR_BITS-1:0]    i_req,
    output vpa_pkg::t_dp_status              o_status,
    output logic [1:0]                       o_res_status,
    output logic [vpa_pkg::ADDR_BITS-1:0]    o_res_start,
    output logic [vpa_pkg::ADDR_BITS-1:0]    o_res_size
);

    localparam int IW = vpa_pkg::IDX_W;
    localparam int CW = vpa_pkg::CNT_W;
    localparam int AW = vpa_pkg::ADDR_BITS;
    localparam int OW = vpa_pkg::OFF_W;

    // configuration
    logic [AW-1:0]               r_mu;
    logic [vpa_pkg::POL_W-1:0]   r_pol;

    // table state
    logic [CW-1:0]               r_cnt, n_cnt;

    // operation registers
    vpa_pkg::t_op                r_op, n_op;
    logic [vpa_pkg::TAG_BITS-1:0] r_tag, n_tag;
    logic [AW-1:0]               r_req, n_req;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_have, n_have;
    logic [CW-1:0]               r_pick, n_pick;
    logic [AW-1:0]               r_pick_start, n_pick_start;
    logic [AW-1:0]               r_pick_size, n_pick_size;
    logic [CW-1:0]               r_src, n_src;
    vpa_pkg::t_entry             r_prev, n_prev;
    vpa_pkg::t_entry             r_ek, n_ek;
    logic                        r_nok, n_nok;
    logic                        r_nfree, n_nfree;
    logic [AW-1:0]               r_nsize, n_nsize;
    logic [1:0]                  r_d, n_d;
    logic [CW-1:0]               r_nc, n_nc;
    logic [OW-1:0]               r_off, n_off;

    // result
    logic [1:0]                  r_res_status, n_res_status;
    logic [AW-1:0]               r_res_start, n_res_start;
    logic [AW-1:0]               r_res_size, n_res_size;

    // ram ports
    logic                        ram_we, ram_re;
    logic [IW-1:0]               ram_waddr, ram_raddr;
    vpa_pkg::t_entry             ram_wdata, ram_rdata;

    logic                        fits, better, pfree;
    logic [AW-1:0]               merged;
    logic [CW-1:0]               m_idx;

    vpa_ram #(
        .WIDTH (vpa_pkg::ENTRY_W),
        .DEPTH (vpa_pkg::MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu  <= vpa_pkg::RESET_UNITS;
            r_pol <= '0;
            r_cnt <= CW'(1);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == vpa_pkg::CFG_MEMORY_UNITS) begin
                    r_mu <= i_cfg_data[AW-1:0];
                end else if (i_cfg_index == vpa_pkg::CFG_FIT_POLICY) begin
                    r_pol <= i_cfg_data[vpa_pkg::POL_W-1:0];
                end
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_tag        <= n_tag;
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_have       <= n_have;
        r_pick       <= n_pick;
        r_pick_start <= n_pick_start;
        r_pick_size  <= n_pick_size;
        r_src        <= n_src;
        r_prev       <= n_prev;
        r_ek         <= n_ek;
        r_nok        <= n_nok;
        r_nfree      <= n_nfree;
        r_nsize      <= n_nsize;
        r_d          <= n_d;
        r_nc         <= n_nc;
        r_off        <= n_off;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_size   <= n_res_size;
    end

    // hole qualification for the word just read
    always_comb begin
        fits = !ram_rdata.used && (ram_rdata.size >= r_req);
        if (r_pol == vpa_pkg::POL_BEST) begin
            better = !r_have || (ram_rdata.size < r_pick_size);
        end else if (r_pol == vpa_pkg::POL_WORST) begin
            better = !r_have || (ram_rdata.size > r_pick_size);
        end else begin
            better = !r_have;
        end
    end

    // merge of a released block with its free neighbors
    always_comb begin
        pfree  = (r_idx != '0) && !r_prev.used;
        merged = r_ek.size + (r_nfree ? r_nsize : AW'(0));
        m_idx  = pfree ? (r_idx - CW'(1)) : r_idx;
    end

    always_comb begin
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_tag        = r_tag;
        n_req        = r_req;
        n_idx        = r_idx;
        n_have       = r_have;
        n_pick       = r_pick;
        n_pick_start = r_pick_start;
        n_pick_size  = r_pick_size;
        n_src        = r_src;
        n_prev       = r_prev;
        n_ek         = r_ek;
        n_nok        = r_nok;
        n_nfree      = r_nfree;
        n_nsize      = r_nsize;
        n_d          = r_d;
        n_nc         = r_nc;
        n_off        = r_off;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_size   = r_res_size;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (i_cmd)
            vpa_pkg::CMD_NONE: begin
            end
            vpa_pkg::CMD_INIT: begin
                ram_we         = 1'b1;
                ram_wdata.size = vpa_pkg::RESET_UNITS;
            end
            vpa_pkg::CMD_LOAD: begin
                n_op   = vpa_pkg::t_op'(i_op);
                n_tag  = i_tag;
                n_req  = i_req;
                n_idx  = '0;
                n_have = 1'b0;
                n_nc   = '0;
                n_off  = '0;
            end
            vpa_pkg::CMD_REINIT: begin
                if (r_mu != '0) begin
                    ram_we         = 1'b1;
                    ram_wdata.size = r_mu;
                    n_cnt          = CW'(1);
                end else begin
                    n_cnt = '0;
                end
                n_res_status = vpa_pkg::ST_OK;
                n_res_start  = '0;
                n_res_size   = '0;
            end
            vpa_pkg::CMD_FAIL_HOLE, vpa_pkg::CMD_FAIL_TAG, vpa_pkg::CMD_FAIL_FULL: begin
                if (i_cmd == vpa_pkg::CMD_FAIL_HOLE) begin
                    n_res_status = vpa_pkg::ST_NO_HOLE;
                end else if (i_cmd == vpa_pkg::CMD_FAIL_TAG) begin
                    n_res_status = vpa_pkg::ST_NO_TAG;
                end else begin
                    n_res_status = vpa_pkg::ST_FULL;
                end
                n_res_start = '0;
                n_res_size  = '0;
            end
            vpa_pkg::CMD_SCAN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx[IW-1:0];
            end
            vpa_pkg::CMD_ALLOC_EVAL: begin
                if (fits && better) begin
                    n_have       = 1'b1;
                    n_pick       = r_idx;
                    n_pick_start = ram_rdata.start;
                    n_pick_size  = ram_rdata.size;
                end
                n_idx = r_idx + CW'(1);
            end
            vpa_pkg::CMD_ALLOC_EXACT: begin
                ram_we          = 1'b1;
                ram_waddr       = r_pick[IW-1:0];
                ram_wdata.start = r_pick_start;
                ram_wdata.size  = r_pick_size;
                ram_wdata.tag   = r_tag;
                ram_wdata.used  = 1'b1;
                n_res_status    = vpa_pkg::ST_OK;
                n_res_start     = r_pick_start;
                n_res_size      = r_pick_size;
            end
            vpa_pkg::CMD_SPLIT_INIT: begin
                n_src = r_cnt;
            end
            vpa_pkg::CMD_MOVE_RD: begin
                ram_re    = 1'b1;
                ram_raddr = IW'(r_src - CW'(1));
            end
            vpa_pkg::CMD_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_src[IW-1:0];
                ram_wdata = ram_rdata;
                n_src     = r_src - CW'(1);
            end
            vpa_pkg::CMD_SPLIT_HOLE: begin
                ram_we          = 1'b1;
                ram_waddr       = IW'(r_pick + CW'(1));
                ram_wdata.start = r_pick_start + r_req;
                ram_wdata.size  = r_pick_size - r_req;
                n_cnt           = r_cnt + CW'(1);
            end
            vpa_pkg::CMD_SPLIT_BLOCK: begin
                ram_we          = 1'b1;
                ram_waddr       = r_pick[IW-1:0];
                ram_wdata.start = r_pick_start;
                ram_wdata.size  = r_req;
                ram_wdata.tag   = r_tag;
                ram_wdata.used  = 1'b1;
                n_res_status    = vpa_pkg::ST_OK;
                n_res_start     = r_pick_start;
                n_res_size      = r_req;
            end
            vpa_pkg::CMD_FREE_HIT: begin
                n_ek         = ram_rdata;
                n_res_status = vpa_pkg::ST_OK;
                n_res_start  = ram_rdata.start;
                n_res_size   = ram_rdata.size;
            end
            vpa_pkg::CMD_FREE_MISS: begin
                n_prev = ram_rdata;
                n_idx  = r_idx + CW'(1);
            end
            vpa_pkg::CMD_NEXT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = IW'(r_idx + CW'(1));
                n_nok     = (r_idx + CW'(1)) < r_cnt;
            end
            vpa_pkg::CMD_NEXT_EVAL: begin
                n_nfree = r_nok && !ram_rdata.used;
                n_nsize = ram_rdata.size;
            end
            vpa_pkg::CMD_MERGE: begin
                ram_we    = 1'b1;
                ram_waddr = m_idx[IW-1:0];
                if (pfree) begin
                    ram_wdata.start = r_prev.start;
                    ram_wdata.size  = r_prev.size + merged;
                end else begin
                    ram_wdata.start = r_ek.start;
                    ram_wdata.size  = merged;
                end
                n_d   = {1'b0, pfree} + {1'b0, r_nfree};
                n_src = m_idx + CW'(1) + CW'({1'b0, pfree} + {1'b0, r_nfree});
            end
            vpa_pkg::CMD_SHIFT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_src[IW-1:0];
            end
            vpa_pkg::CMD_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_src - CW'(r_d));
                ram_wdata = ram_rdata;
                n_src     = r_src + CW'(1);
            end
            vpa_pkg::CMD_FREE_END: begin
                n_cnt = r_cnt - CW'(r_d);
            end
            vpa_pkg::CMD_COMPACT_EVAL: begin
                if (ram_rdata.used) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_nc[IW-1:0];
                    ram_wdata       = ram_rdata;
                    ram_wdata.start = r_off[AW-1:0];
                    n_nc            = r_nc + CW'(1);
                    n_off           = r_off + OW'(ram_rdata.size);
                end
                n_idx = r_idx + CW'(1);
            end
            vpa_pkg::CMD_COMPACT_TAIL: begin
                if (r_off < OW'(r_mu) && r_nc < CW'(vpa_pkg::MAX_ENTRIES)) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_nc[IW-1:0];
                    ram_wdata.start = r_off[AW-1:0];
                    ram_wdata.size  = r_mu - r_off[AW-1:0];
                    n_cnt           = r_nc + CW'(1);
                end else begin
                    n_cnt = r_nc;
                end
                n_res_status = vpa_pkg::ST_OK;
                n_res_start  = '0;
                n_res_size   = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.req_zero   = (r_req == '0);
        o_status.at_end     = (r_idx >= r_cnt);
        o_status.have       = r_have;
        o_status.exact      = (r_pick_size == r_req);
        o_status.full       = (r_cnt >= CW'(vpa_pkg::MAX_ENTRIES));
        o_status.hit        = ram_rdata.used && (ram_rdata.tag == r_tag);
        o_status.move_done  = (r_src == (r_pick + CW'(1)));
        o_status.shift_done = (r_src >= r_cnt);
    end

    assign o_res_status = r_res_status;
    assign o_res_start  = r_res_start;
    assign o_res_size   = r_res_size;

endmodule
